### hdl/urdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_pkg: shared types and constants for the register datagram framer
// Command codes, job descriptor for the front/back queue, CRC-8 helper.
// ----------------------------------------------------------------------------
package urdf_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_REPLY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_WRITE = 2'd0,
    JOB_READ  = 2'd1,
    JOB_REPLY = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_HDR_BAD = 2'd1,
    STATUS_CRC_BAD = 2'd2
  } status_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  addr;
    logic [6:0]  reg_idx;
    logic [31:0] value;
    status_t     status;
  } job_t;

  // CRC-8, poly 0x07, byte fed lsb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int j = 0; j < 8; j++) begin
      if (c[7] ^ data[j]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hdl/urdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_front: command classifier and reply receiver
// Turns commands into jobs; runs the reply CRC/header check.
// ----------------------------------------------------------------------------
module urdf_front
  import urdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [1:0]  cmd,
  input  wire logic [6:0]  reg_idx,
  input  wire logic [31:0] wr_value,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  node_addr,
  output logic             push,
  output job_t             push_job
);

  logic [2:0]  rx_count_r, rx_count_nxt;
  logic [7:0]  rx_crc_r, rx_crc_nxt;
  logic [31:0] rx_data_r, rx_data_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [6:0]  pending_r, pending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= '0;
      rx_crc_r   <= '0;
      rx_data_r  <= '0;
      hdr_bad_r  <= 1'b0;
      pending_r  <= '0;
    end else begin
      rx_count_r <= rx_count_nxt;
      rx_crc_r   <= rx_crc_nxt;
      rx_data_r  <= rx_data_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
      pending_r  <= pending_nxt;
    end
  end

  always_comb begin
    rx_count_nxt     = rx_count_r;
    rx_crc_nxt       = rx_crc_r;
    rx_data_nxt      = rx_data_r;
    hdr_bad_nxt      = hdr_bad_r;
    pending_nxt      = pending_r;
    push             = 1'b0;
    push_job.kind    = JOB_WRITE;
    push_job.addr    = node_addr;
    push_job.reg_idx = reg_idx;
    push_job.value   = wr_value;
    push_job.status  = STATUS_OK;
    if (accept) begin
      case (cmd_t'(cmd))
        CMD_WRITE: begin
          push = 1'b1;
        end
        CMD_READ: begin
          push          = 1'b1;
          push_job.kind = JOB_READ;
          pending_nxt   = reg_idx;
          rx_count_nxt  = '0;
          rx_crc_nxt    = '0;
          rx_data_nxt   = '0;
          hdr_bad_nxt   = 1'b0;
        end
        CMD_REPLY: begin
          if (rx_count_r == 3'd7) begin
            // final byte: CRC check, then receiver back to zero
            push          = 1'b1;
            push_job.kind = JOB_REPLY;
            push_job.value = '0;
            if (hdr_bad_r) begin
              push_job.status = STATUS_HDR_BAD;
            end else if (rx_byte != rx_crc_r) begin
              push_job.status = STATUS_CRC_BAD;
            end else begin
              push_job.value = rx_data_r;
            end
            rx_count_nxt = '0;
            rx_crc_nxt   = '0;
            rx_data_nxt  = '0;
            hdr_bad_nxt  = 1'b0;
          end else begin
            if (rx_count_r == 3'd0 && rx_byte != SYNC_BYTE) begin
              hdr_bad_nxt = 1'b1;
            end else if (rx_count_r == 3'd1 && rx_byte != MASTER_ADDR) begin
              hdr_bad_nxt = 1'b1;
            end else if (rx_count_r == 3'd2 && rx_byte != {1'b0, pending_r}) begin
              hdr_bad_nxt = 1'b1;
            end else if (rx_count_r >= 3'd3) begin
              rx_data_nxt = {rx_data_r[23:0], rx_byte};
            end
            rx_crc_nxt   = crc_feed(rx_crc_r, rx_byte);
            rx_count_nxt = rx_count_r + 3'd1;
          end
        end
        default: begin
          // unused command: dropped
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/urdf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_queue: two-entry job queue
// Decouples the command front from the byte emitter.
// ----------------------------------------------------------------------------
module urdf_queue
  import urdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      pop_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/urdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urdf_back: datagram byte emitter
// One output word per cycle while out_tready allows; running CRC over request bytes.
// ----------------------------------------------------------------------------
module urdf_back
  import urdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_not_empty,
  input  wire job_t                  q_job,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  job_t                  job_r;
  logic                  active_r;
  logic [2:0]            idx_r;
  logic [7:0]            crc_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic       step;
  logic       last;
  logic       is_crc;
  logic [7:0] data_byte;
  logic [7:0] tx_byte;

  assign step  = active_r && (!out_valid_r || out_tready);
  assign q_pop = q_not_empty && (!active_r || (step && last));

  always_comb begin
    case (job_r.kind)
      JOB_WRITE: last = (idx_r == 3'd7);
      JOB_READ:  last = (idx_r == 3'd3);
      default:   last = 1'b1;
    endcase
    is_crc = last && (job_r.kind != JOB_REPLY);
    case (idx_r)
      3'd0:    data_byte = SYNC_BYTE;
      3'd1:    data_byte = job_r.addr;
      3'd2:    data_byte = {job_r.kind == JOB_WRITE, job_r.reg_idx};
      3'd3:    data_byte = job_r.value[31:24];
      3'd4:    data_byte = job_r.value[23:16];
      3'd5:    data_byte = job_r.value[15:8];
      3'd6:    data_byte = job_r.value[7:0];
      default: data_byte = '0;
    endcase
    tx_byte = is_crc ? crc_r : data_byte;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (q_pop) begin
      idx_r <= '0;
      crc_r <= '0;
    end else if (step) begin
      idx_r <= idx_r + 3'd1;
      crc_r <= crc_feed(crc_r, data_byte);
    end
    if (step) begin
      // tlast marks only the CRC byte of a request
      out_last_r <= is_crc;
      if (job_r.kind == JOB_REPLY) begin
        out_data_r <= {4'd0, job_r.value, job_r.status, 1'b1, 8'd0, 1'b0};
      end else begin
        out_data_r <= {4'd0, 32'd0, STATUS_OK, 1'b0, tx_byte, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (step && last) begin
        active_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### hdl/uart_register_datagram_framer.sv
`default_nettype none
// Path: an accepted command goes through the job queue and the emitter job register to the output register.
// Throughput: a write emits eight words, a read four, a finished reply one,
// one word per cycle from the back-end emitter while out_tready is high;
// reply bytes that finish nothing produce no word.
// Reset (rst_n low, synchronous): queue pointers and count, emitter active and valid
// flags, receiver state, pending register and node address return to zero.
// ----------------------------------------------------------------------------
// uart_register_datagram_framer: single-wire register datagram framer
// Front classifies commands and checks reply bytes; a two-deep job queue
// feeds a back end that serializes request datagrams with CRC-8.
// ----------------------------------------------------------------------------
module uart_register_datagram_framer
  import urdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration: node address
  input  wire logic                  cfg_wr_en,
  input  wire logic [7:0]            cfg_wr_data,
  // command words
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // register_index[6:0], write_value[38:7],
                                                 // rx_byte[46:39], zero pad
  input  wire logic [1:0]            in_tuser,   // cmd
  // result words
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // tx_valid[0], tx_byte[8:1],
                                                 // reply_valid[9], reply_status[11:10],
                                                 // reply_value[43:12], zero pad
  output logic                       out_tlast   // tx_last
);

  logic [7:0] node_addr_r;
  logic       accept;
  logic       q_full;
  logic       push;
  job_t       push_job;
  logic       pop;
  logic       q_not_empty;
  job_t       pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= '0;
    end else if (cfg_wr_en) begin
      node_addr_r <= cfg_wr_data;
    end
  end

  // front stalls only when the job queue is full
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  urdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_tuser),
    .reg_idx   (in_tdata[6:0]),
    .wr_value  (in_tdata[38:7]),
    .rx_byte   (in_tdata[46:39]),
    .node_addr (node_addr_r),
    .push      (push),
    .push_job  (push_job)
  );

  urdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_job   (pop_job)
  );

  urdf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (pop_job),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire

### tb/sv/tb_uart_register_datagram_framer.sv
// ----------------------------------------------------------------------------
// tb_uart_register_datagram_framer: self-checking bench for the datagram framer
// Streams write, read and reply-byte commands with random gaps on both sides,
// predicts every request byte and checked reply, and compares each result word
// in arrival order against the predicted stream.
// ----------------------------------------------------------------------------
module tb_uart_register_datagram_framer
  import urdf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;    // decoded as nothing by the block
  localparam int IDLE_PCT          = 10;       // gap / stall chance per cycle, percent
  localparam int MAX_SHOWN         = 10;
  localparam int SETTLE_CYCLES     = 20;       // quiet time before a config write
  localparam int DRAIN_CYCLES      = 50;
  localparam int RANDOM_PER_PHASE  = 75;
  localparam int RANDOM_PHASES     = 6;
  localparam int TIMEOUT_NS        = 3_200_000;

  // damage applied to an otherwise well-formed reply
  typedef enum int {
    FLAW_NONE,    // clean reply, status ok
    FLAW_HEADER,  // header byte wrong, CRC recomputed over the bad header
    FLAW_BOTH,    // header byte wrong and CRC left stale
    FLAW_DATA,    // data byte flipped after the CRC was taken
    FLAW_CRC      // CRC byte itself wrong
  } reply_flaw_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  reg_idx;
    logic [31:0] wr_value;
    logic [7:0]  rx_byte;
  } cmd_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        reply_valid;
    logic [1:0]  reply_status;
    logic [31:0] reply_value;
  } result_word_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [7:0]            cfg_wr_data = 8'h00;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // register_index, write_value, rx_byte
  logic [1:0]            in_tuser    = '0;  // cmd
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // tx_valid, tx_byte, reply_valid,
                                            // reply_status, reply_value
  logic                  out_tlast;         // tx_last

  uart_register_datagram_framer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // words waiting to be driven, and result words still owed by the block
  cmd_word_t    pending_cmds[$];
  result_word_t expected_words[$];
  cmd_word_t    cur_word;

  int n_errors = 0;
  int n_queued = 0;   // commands queued, ignored ones excluded
  bit quiet    = 1'b0; // no gaps or stalls while set

  // framer state as the bench sees it
  logic [7:0]  node_addr_q = 8'h00;
  logic [2:0]  rx_idx      = '0;
  logic [7:0]  rx_crc_acc  = '0;
  logic [31:0] rx_shift    = '0;
  logic        hdr_bad     = 1'b0;
  logic [6:0]  read_reg    = '0;

  // stimulus side: register of the last read request queued
  logic [6:0]  stim_read_reg = '0;

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // reset once at start, then released
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // CRC-8, poly 0x07, zero start, bits taken lsb first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[7] ^ b[k];
      r  = r << 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic clear_receiver();
    rx_idx     = '0;
    rx_crc_acc = '0;
    rx_shift   = '0;
    hdr_bad    = 1'b0;
  endtask

  // Works out the result words one accepted command causes.
  task automatic frame_command(input cmd_word_t w);
    logic [7:0]   dg[0:7];
    logic [7:0]   crc;
    result_word_t r;
    int           len;
    len = 0;
    case (w.cmd)
      CMD_WRITE: begin
        dg  = '{SYNC_BYTE, node_addr_q, {1'b1, w.reg_idx}, w.wr_value[31:24],
                w.wr_value[23:16], w.wr_value[15:8], w.wr_value[7:0], 8'h00};
        len = 8;
      end
      CMD_READ: begin
        dg       = '{SYNC_BYTE, node_addr_q, {1'b0, w.reg_idx}, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00};
        len      = 4;
        read_reg = w.reg_idx;
        clear_receiver();
      end
      CMD_REPLY: begin
        if (rx_idx == 3'd7) begin
          r = '0;
          r.reply_valid = 1'b1;
          // header problems win over a bad CRC
          if (hdr_bad) begin
            r.reply_status = STATUS_HDR_BAD;
          end else if (w.rx_byte != rx_crc_acc) begin
            r.reply_status = STATUS_CRC_BAD;
          end else begin
            r.reply_status = STATUS_OK;
            r.reply_value  = rx_shift;
          end
          expected_words.push_back(r);
          clear_receiver();
        end else begin
          case (rx_idx)
            3'd0:    if (w.rx_byte != SYNC_BYTE) hdr_bad = 1'b1;
            3'd1:    if (w.rx_byte != MASTER_ADDR) hdr_bad = 1'b1;
            3'd2:    if (w.rx_byte != {1'b0, read_reg}) hdr_bad = 1'b1;
            default: rx_shift = {rx_shift[23:0], w.rx_byte};
          endcase
          rx_crc_acc = crc8_step(rx_crc_acc, w.rx_byte);
          rx_idx     = rx_idx + 3'd1;
        end
      end
      default: ;  // unused code: nothing happens
    endcase
    if (len > 0) begin
      crc = 8'h00;
      for (int i = 0; i < len - 1; i++) begin
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = dg[i];
        expected_words.push_back(r);
        crc = crc8_step(crc, dg[i]);
      end
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte  = crc;
      r.tx_last  = 1'b1;
      expected_words.push_back(r);
    end
  endtask

  // Driver: one command word per handshake; valid held until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) frame_command(cur_word);
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_word  = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_word.cmd;
          in_tdata  <= {1'b0, cur_word.rx_byte, cur_word.wr_value, cur_word.reg_idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input result_word_t want,
                                 input result_word_t got);
    n_errors++;
    if (n_errors <= MAX_SHOWN)
      $display("%0t: %s exp %0b/%02h/%0b %0b/%0d/%08h got %0b/%02h/%0b %0b/%0d/%08h",
               $realtime, what,
               want.tx_valid, want.tx_byte, want.tx_last, want.reply_valid,
               want.reply_status, want.reply_value,
               got.tx_valid, got.tx_byte, got.tx_last, got.reply_valid,
               got.reply_status, got.reply_value);
  endtask

  // Monitor: random backpressure, check every accepted result word in order.
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[0], out_tdata[8:1], out_tlast, out_tdata[9],
                out_tdata[11:10], out_tdata[43:12]};
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word:", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.tx_last !== want.tx_last || got.reply_valid !== want.reply_valid ||
              got.reply_status !== want.reply_status ||
              got.reply_value !== want.reply_value)
            report_mismatch("mismatch:", want, got);
        end
      end
      out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic queue_word(input logic [1:0] cmd, input logic [6:0] ri,
                            input logic [31:0] v, input logic [7:0] b);
    pending_cmds.push_back('{cmd, ri, v, b});
    if (cmd != CMD_UNUSED) n_queued++;
  endtask

  task automatic queue_read(input logic [6:0] ri);
    stim_read_reg = ri;
    queue_word(CMD_READ, ri, $urandom, 8'($urandom));
  endtask

  // Eight-byte reply for register ri; optionally damaged, cut short, or with a
  // write request slipped in before one of its bytes.
  task automatic queue_reply(input logic [6:0] ri, input logic [31:0] data,
                             input reply_flaw_t flaw, input int cut, input bit mid_write);
    logic [7:0] b[0:7];
    logic [7:0] crc;
    logic [7:0] flip;
    int         wpos;
    b    = '{SYNC_BYTE, MASTER_ADDR, {1'b0, ri}, data[31:24], data[23:16],
             data[15:8], data[7:0], 8'h00};
    flip = 8'h01 << $urandom_range(0, 7);
    if (flaw == FLAW_HEADER) b[$urandom_range(0, 2)] ^= flip;
    crc = 8'h00;
    for (int i = 0; i < 7; i++) crc = crc8_step(crc, b[i]);
    b[7] = crc;
    case (flaw)
      FLAW_BOTH: b[$urandom_range(0, 2)] ^= flip;
      FLAW_DATA: b[$urandom_range(3, 6)] ^= flip;
      FLAW_CRC:  b[7] ^= flip;
      default:   ;
    endcase
    wpos = mid_write ? $urandom_range(0, cut - 1) : -1;
    for (int i = 0; i < cut; i++) begin
      if (i == wpos) queue_word(CMD_WRITE, 7'($urandom), rand_word(), 8'($urandom));
      queue_word(CMD_REPLY, 7'($urandom), $urandom, b[i]);
    end
  endtask

  // Block must be fully quiet before a config write: nothing queued, nothing
  // in flight, plus a few cycles for reply bytes that produce no word.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_tvalid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_addr(input logic [7:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    node_addr_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic reply_flaw_t pick_flaw();
    case ($urandom_range(0, 9))
      0:       return FLAW_HEADER;
      1:       return FLAW_BOTH;
      2:       return FLAW_DATA;
      3:       return FLAW_CRC;
      default: return FLAW_NONE;
    endcase
  endfunction

  initial begin
    int          goal;
    int          pick;
    int          n;
    logic [6:0]  ri;
    logic [7:0]  nb;
    while (!rst_n) @(posedge clk);

    // --- directed ---
    // unused command code first: must leave no trace
    queue_word(CMD_UNUSED, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    // reply with no read before it: checked against register 0 from reset
    queue_reply(7'd0, 32'hFFFF_FFFF, FLAW_NONE, 8, 1'b0);

    write_node_addr(8'hFF);
    queue_word(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'h00);
    queue_word(CMD_WRITE, 7'h00, 32'h0000_0000, 8'hFF);
    // bad CRC only, with a write request slipped in before one of the reply bytes
    queue_read(7'h7F);
    queue_reply(7'h7F, 32'h8000_0001, FLAW_CRC, 8, 1'b1);
    // header and CRC both wrong: header status wins
    queue_read(7'h00);
    queue_reply(7'h00, 32'h1234_5678, FLAW_BOTH, 8, 1'b0);

    // --- random phases, node address swept across extremes and randoms ---
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       nb = 8'h00;
        1:       nb = 8'hFF;
        default: nb = 8'($urandom_range(0, 255));
      endcase
      write_node_addr(nb);
      quiet = (ph == 2);  // one long stretch with no gaps and no stalls
      goal  = n_queued + RANDOM_PER_PHASE;
      while (n_queued < goal) begin
        pick = $urandom_range(0, 99);
        ri   = 7'($urandom_range(0, 127));
        if (pick < 45) begin
          // well-formed transaction, mostly clean
          queue_read(ri);
          queue_reply(ri, rand_word(), pick_flaw(), 8, $urandom_range(0, 9) == 0);
        end else if (pick < 60) begin
          queue_word(CMD_WRITE, ri, rand_word(), 8'($urandom));
        end else if (pick < 70) begin
          // read followed by a reply cut short
          queue_read(ri);
          queue_reply(ri, rand_word(), FLAW_NONE, $urandom_range(1, 7), 1'b0);
        end else if (pick < 80) begin
          // raw noise bytes, biased toward header values
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
              0:       nb = SYNC_BYTE;
              1:       nb = MASTER_ADDR;
              default: nb = 8'($urandom);
            endcase
            queue_word(CMD_REPLY, 7'($urandom), $urandom, nb);
          end
        end else if (pick < 85) begin
          queue_word(CMD_UNUSED, 7'($urandom), $urandom, 8'($urandom));
        end else if (pick < 93) begin
          // another reply for the last read register, no fresh request
          queue_reply(stim_read_reg, rand_word(), pick_flaw(), 8, 1'b0);
        end else begin
          queue_read(ri);
        end
      end
    end
    quiet = 1'b0;

    // --- drain ---
    while (pending_cmds.size() != 0 || in_tvalid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_errors += expected_words.size();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hdl/urdf_pkg.sv
hdl/urdf_front.sv
hdl/urdf_queue.sv
hdl/urdf_back.sv
hdl/uart_register_datagram_framer.sv
tb/sv/tb_uart_register_datagram_framer.sv
